@@ design/vus_pkg.sv @@
// Shared types, codes and reset constants for the utterance segmenter.
`timescale 1ns / 1ps

package vus_pkg;

  // Fixed field widths.
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned NSAMP_W   = 20;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned PROB_W    = 16;
  localparam int unsigned CAUSE_W   = 2;
  localparam int unsigned START_W   = 48;
  localparam int unsigned LEN_W     = 20;
  localparam int unsigned ONSET_W   = 8;
  localparam int unsigned PREROLL_W = 16;
  localparam int unsigned SIL_W     = 24;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 20;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_FRAME     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FLUSH_ALL = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FLUSH_MIN = 2'd2;

  // VAD status code meaning the model produced a probability.
  localparam logic [STATUS_W-1:0] VAD_RAN = 2'd1;

  // Result codes.
  localparam logic RES_EMITTED   = 1'b0;
  localparam logic RES_DISCARDED = 1'b1;

  localparam logic [CAUSE_W-1:0] CAUSE_OVERFLOW = 2'd0;
  localparam logic [CAUSE_W-1:0] CAUSE_EOU      = 2'd1;
  localparam logic [CAUSE_W-1:0] CAUSE_FLUSH    = 2'd2;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ONSET_THR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN_THR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONSET_FRM   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PREROLL_MAX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EOU_SILENCE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SEGMENT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_CAP = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_VAD_FRM_LEN = 3'd7;

  // Register reset values.
  localparam logic [15:0] RST_ONSET_THR   = 16'd32768;
  localparam logic [15:0] RST_SUSTAIN_THR = 16'd22938;
  localparam logic [7:0]  RST_ONSET_FRM   = 8'd3;
  localparam logic [15:0] RST_PREROLL_MAX = 16'd8000;
  localparam logic [19:0] RST_EOU_SILENCE = 20'd24000;
  localparam logic [19:0] RST_MIN_SEGMENT = 20'd16000;
  localparam logic [19:0] RST_SEGMENT_CAP = 20'd480000;
  localparam logic [15:0] RST_VAD_FRM_LEN = 16'd512;

  // Saturation limits.
  localparam logic [SIL_W-1:0]   SIL_MAX   = 24'hFF_FFFF;
  localparam logic [ONSET_W-1:0] ONSET_MAX = 8'hFF;

  typedef struct packed {
    logic [15:0] onset_threshold;
    logic [15:0] sustain_threshold;
    logic [7:0]  onset_frame_cnt;
    logic [15:0] preroll_limit;
    logic [19:0] eou_sil_len;
    logic [19:0] min_seg_len;
    logic [19:0] segment_cap;
    logic [15:0] vad_frame_len;
  } cfg_t;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [NSAMP_W-1:0]  sample_count;
    logic [STATUS_W-1:0] vad_status;
    logic [PROB_W-1:0]   speech_prob;
  } in_item_t;

  typedef struct packed {
    logic               event_res;
    logic [CAUSE_W-1:0] cause;
    logic [START_W-1:0] start_sample;
    logic [LEN_W-1:0]   seg_len;
  } out_item_t;

endpackage : vus_pkg

@@ design/vus_cfg_regs.sv @@
// Configuration register file with reset values and an indexed write port.
`timescale 1ns / 1ps

module vus_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [vus_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [vus_pkg::CFG_DAT_W-1:0] cfg_wdata_i,
  output vus_pkg::cfg_t                 cfg_o
);
  import vus_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_ONSET_THR:   cfg_d.onset_threshold   = cfg_wdata_i[15:0];
        REG_SUSTAIN_THR: cfg_d.sustain_threshold = cfg_wdata_i[15:0];
        REG_ONSET_FRM:   cfg_d.onset_frame_cnt   = cfg_wdata_i[7:0];
        REG_PREROLL_MAX: cfg_d.preroll_limit     = cfg_wdata_i[15:0];
        REG_EOU_SILENCE: cfg_d.eou_sil_len       = cfg_wdata_i;
        REG_MIN_SEGMENT: cfg_d.min_seg_len       = cfg_wdata_i;
        REG_SEGMENT_CAP: cfg_d.segment_cap       = cfg_wdata_i;
        REG_VAD_FRM_LEN: cfg_d.vad_frame_len     = cfg_wdata_i[15:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.onset_threshold   <= RST_ONSET_THR;
      cfg_q.sustain_threshold <= RST_SUSTAIN_THR;
      cfg_q.onset_frame_cnt   <= RST_ONSET_FRM;
      cfg_q.preroll_limit     <= RST_PREROLL_MAX;
      cfg_q.eou_sil_len       <= RST_EOU_SILENCE;
      cfg_q.min_seg_len       <= RST_MIN_SEGMENT;
      cfg_q.segment_cap       <= RST_SEGMENT_CAP;
      cfg_q.vad_frame_len     <= RST_VAD_FRM_LEN;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule : vus_cfg_regs

@@ design/vus_seg_core.sv @@
// Segment state registers and the single-pass update for one transaction.
`timescale 1ns / 1ps

module vus_seg_core #(
  parameter int unsigned OFFSET_WIDTH = 48,
  parameter int unsigned COUNT_WIDTH  = 20
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  vus_pkg::in_item_t  item_i,
  input  vus_pkg::cfg_t      cfg_i,
  output logic               res_valid_o,
  output vus_pkg::out_item_t res_o
);
  import vus_pkg::*;

  localparam int unsigned OW    = OFFSET_WIDTH;
  localparam int unsigned CW    = COUNT_WIDTH;
  localparam int unsigned NW    = (CW < NSAMP_W) ? CW : NSAMP_W;
  localparam int unsigned SW    = ((CW > NSAMP_W) ? CW : NSAMP_W) + 1;
  localparam int unsigned EXT_W = (OW > START_W) ? OW : START_W;

  logic [CW-1:0]        seg_q, seg_d;
  logic [PREROLL_W-1:0] pre_q, pre_d;
  logic [ONSET_W-1:0]   onset_q, onset_d;
  logic [SIL_W-1:0]     sil_q, sil_d;
  logic [OW-1:0]        ofs_q, ofs_d;
  logic [START_W-1:0]   start_q, start_d;

  logic [NW-1:0]        n;
  logic [SW-1:0]        n_s, seg_s, cap_s, min_s;
  logic                 is_flush, is_frame, ovf, vad_ok, speech;
  logic [PROB_W-1:0]    thr;
  logic [CW-1:0]        seg1, seg_base, seg_new;
  logic [PREROLL_W-1:0] pre1, pre2, keep;
  logic [PREROLL_W:0]   pre_sum;
  logic [ONSET_W-1:0]   on1, on2;
  logic [SIL_W-1:0]     sil1, sil2, sil3;
  logic [SIL_W:0]       sil_sum;
  logic [OW-1:0]        ofs_next;
  logic [START_W-1:0]   ofs_start, back_start, cur_start;
  logic [EXT_W-1:0]     ofs_ext, back_ext;

  assign n     = item_i.sample_count[NW-1:0];
  assign n_s   = SW'(n);
  assign seg_s = SW'(seg_q);
  assign cap_s = SW'(cfg_i.segment_cap);
  assign min_s = SW'(cfg_i.min_seg_len);

  // A zero-length frame behaves as a plain flush.
  assign is_flush = (item_i.cmd == CMD_FLUSH_ALL) || (item_i.cmd == CMD_FLUSH_MIN) ||
                    ((item_i.cmd == CMD_FRAME) && (n == '0));
  assign is_frame = (item_i.cmd == CMD_FRAME) && (n != '0);

  assign ofs_next = ofs_q + OW'(n);
  assign ofs_ext  = EXT_W'(ofs_q);
  assign back_ext = EXT_W'(ofs_q - OW'(pre2));

  // Start index of a segment opening on this frame.
  assign ofs_start  = ofs_ext[START_W-1:0];
  assign back_start = (ofs_q >= OW'(pre2)) ? back_ext[START_W-1:0] : '0;

  // Capacity overflow empties the open segment before the frame is counted.
  assign ovf  = (seg_s + n_s) > cap_s;
  assign seg1 = ovf ? '0 : seg_q;
  assign pre1 = ovf ? '0 : pre_q;
  assign on1  = ovf ? '0 : onset_q;
  assign sil1 = ovf ? '0 : sil_q;

  assign vad_ok  = (item_i.vad_status == VAD_RAN) && (n_s == SW'(cfg_i.vad_frame_len));
  assign thr     = (seg1 == '0) ? cfg_i.onset_threshold : cfg_i.sustain_threshold;
  assign speech  = item_i.speech_prob >= thr;
  assign sil_sum = {1'b0, sil1} + (SIL_W + 1)'(n);

  always_comb begin
    on2  = on1;
    sil2 = sil1;
    if (vad_ok) begin
      if (speech) begin
        sil2 = '0;
        on2  = (on1 == ONSET_MAX) ? on1 : on1 + 1'b1;
      end else begin
        sil2 = sil_sum[SIL_W] ? SIL_MAX : sil_sum[SIL_W-1:0];
        on2  = '0;
      end
    end
  end

  // Preroll accumulation while waiting for onset.
  assign keep    = (n_s > SW'(cfg_i.preroll_limit)) ? cfg_i.preroll_limit : PREROLL_W'(n);
  assign pre_sum = {1'b0, pre1} + {1'b0, keep};

  // Preroll that does not fit alongside the frame is dropped at onset.
  assign pre2 = ((SW'(pre1) + n_s) > cap_s) ? '0 : pre1;

  always_comb begin
    if (seg1 != '0) begin
      seg_base  = seg1;
      sil3      = sil2;
      cur_start = start_q;
    end else begin
      seg_base  = CW'(pre2);
      sil3      = '0;
      cur_start = (pre2 != '0) ? back_start : ofs_start;
    end
  end

  assign seg_new = CW'(SW'(seg_base) + n_s);

  always_comb begin
    seg_d       = seg_q;
    pre_d       = pre_q;
    onset_d     = onset_q;
    sil_d       = sil_q;
    ofs_d       = ofs_q;
    start_d     = start_q;
    res_valid_o = 1'b0;
    res_o.event_res    = RES_EMITTED;
    res_o.cause        = CAUSE_FLUSH;
    res_o.start_sample = start_q;
    res_o.seg_len      = LEN_W'(seg_q);

    if (is_flush) begin
      if (seg_q != '0) begin
        res_valid_o = 1'b1;
        res_o.event_res = ((item_i.cmd == CMD_FLUSH_MIN) && (seg_s <= min_s)) ?
                          RES_DISCARDED : RES_EMITTED;
        seg_d   = '0;
        pre_d   = '0;
        onset_d = '0;
        sil_d   = '0;
      end
    end else if (is_frame) begin
      ofs_d = ofs_next;
      if (n_s <= cap_s) begin
        // Overflow result takes priority; the frame then goes on as if waiting.
        if (ovf) begin
          res_valid_o = 1'b1;
          res_o.event_res = (seg_s > min_s) ? RES_EMITTED : RES_DISCARDED;
          res_o.cause     = CAUSE_OVERFLOW;
          start_d         = ofs_start;
        end
        onset_d = on2;
        if ((seg1 == '0) && (on2 < cfg_i.onset_frame_cnt)) begin
          seg_d = '0;
          sil_d = sil2;
          pre_d = (pre_sum > {1'b0, cfg_i.preroll_limit}) ? cfg_i.preroll_limit :
                                                            pre_sum[PREROLL_W-1:0];
        end else begin
          seg_d   = seg_new;
          sil_d   = sil3;
          pre_d   = '0;
          start_d = cur_start;
          if (!ovf && (sil3 >= SIL_W'(cfg_i.eou_sil_len))) begin
            res_valid_o        = 1'b1;
            res_o.cause        = CAUSE_EOU;
            res_o.start_sample = cur_start;
            res_o.seg_len      = LEN_W'(seg_new);
            seg_d   = '0;
            onset_d = '0;
            sil_d   = '0;
            if (SW'(seg_new) > min_s) begin
              res_o.event_res = RES_EMITTED;
            end else begin
              res_o.event_res = RES_DISCARDED;
              start_d = START_W'(EXT_W'(ofs_next));
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q   <= '0;
      pre_q   <= '0;
      onset_q <= '0;
      sil_q   <= '0;
      ofs_q   <= '0;
      start_q <= '0;
    end else if (fire_i) begin
      seg_q   <= seg_d;
      pre_q   <= pre_d;
      onset_q <= onset_d;
      sil_q   <= sil_d;
      ofs_q   <= ofs_d;
      start_q <= start_d;
    end
  end

endmodule : vus_seg_core

@@ design/vad_utterance_segmenter_unit.sv @@
// Top level of the utterance segmenter: input register, segment core, result register.
`timescale 1ns / 1ps

// Speech endpointing on sample counts. Each input transaction is an audio
// frame (sample count plus VAD verdict) or a flush command; each produces
// zero or one segment event carrying the event result, the cause, the
// start sample and the segment length.
// Both channels use valid/ready. An accepted transaction lands in an input
// register; once the output register can take its result, the segment core
// updates its counters from it and, if an event results, writes the event
// into the output register, which drives out_valid_o. The block takes
// one transaction per cycle for as long as the receiver keeps out_ready_i
// high; the single output register is what limits the rate.
// When the receiver stalls with an event pending, the held input
// transaction waits in the input register whether or not it gives an event,
// so in_ready_o drops once both registers are occupied.
// Configuration registers are written through cfg_we_i/cfg_index_i/
// cfg_wdata_i. The user must write them only while the block is idle; the
// block itself does not enforce this.
// Reset clears all counters, the sample offset and both valid flags, and
// loads the configuration registers with their default values.
module vad_utterance_segmenter_unit #(
  parameter int unsigned OFFSET_WIDTH = 48,
  parameter int unsigned COUNT_WIDTH  = 20
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  vus_pkg::in_item_t             in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output vus_pkg::out_item_t            out_item_o,
  input  logic                          cfg_we_i,
  input  logic [vus_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [vus_pkg::CFG_DAT_W-1:0] cfg_wdata_i
);
  import vus_pkg::*;

  cfg_t      cfg;
  in_item_t  in_q;
  logic      in_valid_q, in_valid_d;
  out_item_t out_q;
  logic      out_valid_q, out_valid_d;
  logic      advance;
  logic      res_valid;
  out_item_t res;

  vus_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  vus_seg_core #(
    .OFFSET_WIDTH (OFFSET_WIDTH),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (advance),
    .item_i      (in_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // The held transaction moves on whenever the result register can take
  // whatever it produces.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_valid_i && in_ready_o) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  assign out_valid_d = (out_valid_q && !out_ready_i) || (advance && res_valid);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_item_i;
    end
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule : vad_utterance_segmenter_unit

@@ verif/tb_vad_utterance_segmenter_unit.sv @@
// Self-checking testbench for the utterance segmenter: random and directed frames against a predictor.
`timescale 1ns / 1ps

// The testbench drives frame and flush transactions into the segmenter and
// works out, at the moment each input transaction is accepted, which segment
// event (if any) it must produce. Its own copy of the counters and the
// configuration is kept for this. Every event leaving the block is checked
// field by field against the oldest event still due.
//
// Stimulus runs in phases. Between phases the block is left idle, all due
// events are collected, and a new configuration is written. The first random
// phase keeps the reset configuration. A short directed phase follows with a
// small configuration that makes onset, preroll, end of utterance, capacity
// overflow and both flush kinds easy to reach. Random phases then use typical
// settings, the highest and lowest legal settings, and the two out-of-range
// settings (onset on any frame, no capacity at all).
//
// The sender works in bursts separated by gaps and the receiver stalls on a
// pattern of its own, so that bubbles land on every part of the pipeline.
// Inputs change on the falling edge; handshakes are sampled on the rising
// edge. A watchdog ends the run if no transaction moves for too long.
module tb_vad_utterance_segmenter_unit;

  import vus_pkg::*;

  // Longest stretch with no accepted transaction before the run is abandoned.
  // A correct run never gets near it: sender gaps, receiver stalls and the
  // pause for a configuration write are each far shorter.
  localparam int unsigned QUIET_LIMIT   = 1000;
  // Cycles left after the last due event so that the pipeline has
  // emptied of transactions that give no event.
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned MAX_REPORTS   = 100;

  // Codes the package leaves unnamed, used to reach the ignored cases.
  localparam logic [CMD_W-1:0]    CMD_UNUSED    = 2'd3;
  localparam logic [STATUS_W-1:0] VAD_ABSENT    = 2'd0;
  localparam logic [STATUS_W-1:0] VAD_FAILED    = 2'd2;
  localparam logic [STATUS_W-1:0] VAD_UNDEFINED = 2'd3;

  typedef enum {
    CFG_TYPICAL,
    CFG_HIGHEST,
    CFG_LOWEST,
    CFG_ONSET_ZERO,
    CFG_NO_CAPACITY
  } cfg_flavour_e;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  in_item_t             in_item_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  out_item_t            out_item_o;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata_i = '0;

  // Frames waiting to be sent, and segment events the block still owes us.
  in_item_t  in_q[$];
  out_item_t events_due[$];
  out_item_t due_ev;

  // Shadow of the configuration registers and of the segmenter counters.
  cfg_t             live_cfg;
  logic [LEN_W-1:0]     ep_seg_len  = '0;
  logic [PREROLL_W-1:0] ep_preroll  = '0;
  logic [ONSET_W-1:0]   ep_onset    = '0;
  logic [SIL_W-1:0]     ep_silence  = '0;
  logic [START_W-1:0]   ep_offset   = '0;
  logic [START_W-1:0]   ep_start    = '0;

  // Handshake bookkeeping for the sender, the receiver and the watchdog.
  logic        in_taken     = 1'b0;
  int unsigned send_burst   = 0;
  int unsigned send_gap     = 0;
  int unsigned rdy_run      = 0;
  int unsigned rdy_stall    = 0;
  int unsigned quiet_cycles = 0;
  int unsigned error_count  = 0;
  logic        talking      = 1'b0;

  vad_utterance_segmenter_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic flag_error(input string what);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("[%0t] MISMATCH: %s", $time, what);
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      flag_error($sformatf("%s: got %0d, expected %0d", name, got, want));
    end
  endtask

  // Records the open segment as an event that must come out, then clears
  // the segment counters just as the block does when a segment closes.
  task automatic close_segment(input logic res, input logic [CAUSE_W-1:0] why);
    out_item_t ev;
    ev.event_res    = res;
    ev.cause        = why;
    ev.start_sample = ep_start;
    ev.seg_len      = ep_seg_len;
    events_due.push_back(ev);
    ep_seg_len = '0;
    ep_preroll = '0;
    ep_onset   = '0;
    ep_silence = '0;
  endtask

  // Advances the shadow segmenter by one accepted transaction.
  task automatic step_endpointer(input in_item_t it);
    logic [CMD_W-1:0] op;
    logic [63:0]      n;
    logic [63:0]      sum;
    logic [63:0]      keep;
    logic [63:0]      thr;
    logic             overflowed;
    op         = it.cmd;
    n          = 64'(it.sample_count);
    overflowed = 1'b0;
    // A frame with no samples is treated as an unconditional flush.
    if (op == CMD_FRAME && n == 0) begin
      op = CMD_FLUSH_ALL;
    end
    if (op == CMD_FLUSH_ALL || op == CMD_FLUSH_MIN) begin
      // A flush with nothing open changes nothing and reports nothing.
      if (ep_seg_len != '0) begin
        if (op == CMD_FLUSH_MIN && ep_seg_len <= live_cfg.min_seg_len) begin
          close_segment(RES_DISCARDED, CAUSE_FLUSH);
        end else begin
          close_segment(RES_EMITTED, CAUSE_FLUSH);
        end
      end
      return;
    end
    if (op != CMD_FRAME) begin
      return;
    end
    // A frame too big for the buffer only moves the global sample index on.
    if (n > 64'(live_cfg.segment_cap)) begin
      ep_offset = ep_offset + START_W'(n);
      return;
    end
    // Capacity overflow closes the open segment; the frame then starts afresh.
    if (64'(ep_seg_len) + n > 64'(live_cfg.segment_cap)) begin
      close_segment((ep_seg_len > live_cfg.min_seg_len) ? RES_EMITTED : RES_DISCARDED,
                    CAUSE_OVERFLOW);
      ep_start   = ep_offset;
      overflowed = 1'b1;
    end
    // Only a frame of the model's length with a valid verdict moves the
    // onset and silence counters.
    if (it.vad_status == VAD_RAN && n == 64'(live_cfg.vad_frame_len)) begin
      thr = (ep_seg_len == '0) ? 64'(live_cfg.onset_threshold)
                               : 64'(live_cfg.sustain_threshold);
      if (64'(it.speech_prob) >= thr) begin
        ep_silence = '0;
        if (ep_onset != ONSET_MAX) begin
          ep_onset = ep_onset + 1'b1;
        end
      end else begin
        sum        = 64'(ep_silence) + n;
        ep_silence = (sum > 64'(SIL_MAX)) ? SIL_MAX : SIL_W'(sum);
        ep_onset   = '0;
      end
    end
    if (ep_seg_len == '0) begin
      if (ep_onset < live_cfg.onset_frame_cnt) begin
        // Still waiting: keep a bounded preroll of recent audio.
        keep       = (n > 64'(live_cfg.preroll_limit)) ? 64'(live_cfg.preroll_limit) : n;
        sum        = 64'(ep_preroll) + keep;
        ep_preroll = (sum > 64'(live_cfg.preroll_limit)) ? live_cfg.preroll_limit
                                                         : PREROLL_W'(sum);
        ep_offset  = ep_offset + START_W'(n);
        return;
      end
      // Onset confirmed. A preroll that would not fit beside the frame is dropped.
      if (64'(ep_preroll) + n > 64'(live_cfg.segment_cap)) begin
        ep_preroll = '0;
      end
      if (ep_preroll != '0) begin
        ep_seg_len = LEN_W'(ep_preroll);
        ep_start   = (ep_offset >= START_W'(ep_preroll))
                   ? ep_offset - START_W'(ep_preroll) : '0;
        ep_preroll = '0;
      end else begin
        ep_start = ep_offset;
      end
      ep_silence = '0;
    end
    ep_seg_len = ep_seg_len + LEN_W'(n);
    ep_offset  = ep_offset + START_W'(n);
    // An overflow frame never also closes on silence.
    if (overflowed) begin
      return;
    end
    if (64'(ep_silence) >= 64'(live_cfg.eou_sil_len)) begin
      if (ep_seg_len > live_cfg.min_seg_len) begin
        close_segment(RES_EMITTED, CAUSE_EOU);
      end else begin
        close_segment(RES_DISCARDED, CAUSE_EOU);
        ep_start = ep_offset;
      end
    end
  endtask

  function automatic in_item_t frame_item(input logic [CMD_W-1:0] cmd,
                                          input int unsigned n,
                                          input logic [STATUS_W-1:0] status,
                                          input int unsigned prob);
    in_item_t it;
    it.cmd          = cmd;
    it.sample_count = NSAMP_W'(n);
    it.vad_status   = status;
    it.speech_prob  = PROB_W'(prob);
    return it;
  endfunction

  function automatic cfg_t pick_config(input cfg_flavour_e flavour);
    cfg_t        c;
    int unsigned vlen;
    int unsigned onset;
    vlen                = $urandom_range(1, 600);
    onset               = $urandom_range(16'h1000, 16'hF000);
    c.vad_frame_len     = 16'(vlen);
    c.onset_threshold   = 16'(onset);
    // The sustain threshold is normally the lower one, but not always.
    c.sustain_threshold = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(onset, 16'hFFFF))
                                                      : 16'($urandom_range(0, onset));
    c.onset_frame_cnt   = 8'($urandom_range(1, 4));
    c.preroll_limit     = 16'($urandom_range(0, 4 * vlen));
    c.eou_sil_len       = 20'(vlen * $urandom_range(0, 5) + $urandom_range(0, vlen - 1));
    c.min_seg_len       = 20'(vlen * $urandom_range(0, 12));
    c.segment_cap       = 20'(vlen * $urandom_range(3, 40) + $urandom_range(0, vlen));
    case (flavour)
      CFG_HIGHEST: begin
        c = '{16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 16'hFFFF};
      end
      CFG_LOWEST: begin
        c = '{16'h0000, 16'h0000, 8'd1, 16'h0000, 20'h00000, 20'h00000, 20'd1, 16'd1};
      end
      CFG_ONSET_ZERO: begin
        c.onset_frame_cnt = '0;
      end
      CFG_NO_CAPACITY: begin
        c.segment_cap = '0;
      end
      default: begin
      end
    endcase
    return c;
  endfunction

  // Mostly well-formed audio: frames of the model's length whose verdicts
  // follow alternating runs of speech and silence, so that segments open,
  // sustain and close. The rest is flushes, odd lengths and pure noise.
  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned roll;
    int unsigned hi_thr;
    int unsigned lo_thr;
    int unsigned cap_span;
    roll     = $urandom_range(0, 99);
    hi_thr   = 32'((live_cfg.onset_threshold > live_cfg.sustain_threshold)
                   ? live_cfg.onset_threshold : live_cfg.sustain_threshold);
    lo_thr   = 32'((live_cfg.onset_threshold > live_cfg.sustain_threshold)
                   ? live_cfg.sustain_threshold : live_cfg.onset_threshold);
    cap_span = 32'(live_cfg.segment_cap);
    cap_span = cap_span + cap_span / 4;
    if ($urandom_range(0, 9) == 0) begin
      talking = !talking;
    end
    it.cmd          = CMD_FRAME;
    it.sample_count = NSAMP_W'(live_cfg.vad_frame_len);
    it.vad_status   = VAD_RAN;
    it.speech_prob  = PROB_W'($urandom_range(0, 16'hFFFF));
    if (roll < 3) begin
      it.cmd          = CMD_W'($urandom_range(0, 3));
      it.sample_count = NSAMP_W'($urandom);
      it.vad_status   = STATUS_W'($urandom_range(0, 3));
    end else if (roll < 7) begin
      it.cmd          = (roll < 5) ? CMD_FLUSH_ALL : CMD_FLUSH_MIN;
      it.sample_count = NSAMP_W'($urandom);
      it.vad_status   = STATUS_W'($urandom_range(0, 3));
    end else if (roll < 15) begin
      it.sample_count = NSAMP_W'($urandom_range(0, cap_span));
      it.vad_status   = STATUS_W'($urandom_range(0, 3));
    end else begin
      if (roll < 19) begin
        it.vad_status = STATUS_W'($urandom_range(0, 3));
      end
      if (roll < 25) begin
        // Probabilities right on or just under a threshold.
        case ($urandom_range(0, 3))
          0:       it.speech_prob = live_cfg.onset_threshold;
          1:       it.speech_prob = live_cfg.onset_threshold - 1'b1;
          2:       it.speech_prob = live_cfg.sustain_threshold;
          default: it.speech_prob = live_cfg.sustain_threshold - 1'b1;
        endcase
      end else if (talking) begin
        it.speech_prob = PROB_W'($urandom_range(hi_thr, 16'hFFFF));
      end else if (lo_thr == 0) begin
        it.speech_prob = '0;
      end else begin
        it.speech_prob = PROB_W'($urandom_range(0, lo_thr - 1));
      end
    end
    return it;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DAT_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = data;
  endtask

  // Writes every register in turn; only called while the block is idle.
  task automatic apply_config(input cfg_t c);
    write_reg(REG_ONSET_THR,   CFG_DAT_W'(c.onset_threshold));
    write_reg(REG_SUSTAIN_THR, CFG_DAT_W'(c.sustain_threshold));
    write_reg(REG_ONSET_FRM,   CFG_DAT_W'(c.onset_frame_cnt));
    write_reg(REG_PREROLL_MAX, CFG_DAT_W'(c.preroll_limit));
    write_reg(REG_EOU_SILENCE, CFG_DAT_W'(c.eou_sil_len));
    write_reg(REG_MIN_SEGMENT, CFG_DAT_W'(c.min_seg_len));
    write_reg(REG_SEGMENT_CAP, CFG_DAT_W'(c.segment_cap));
    write_reg(REG_VAD_FRM_LEN, CFG_DAT_W'(c.vad_frame_len));
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    live_cfg = c;
  endtask

  // Waits until every frame has been taken and every due event has arrived,
  // then lets the pipeline empty of frames that give no event.
  task automatic wait_idle();
    while (in_q.size() != 0 || events_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_random_phase(input cfg_flavour_e flavour, input int unsigned count);
    apply_config(pick_config(flavour));
    repeat (count) in_q.push_back(random_item());
    wait_idle();
  endtask

  // Stimulus: reset, then the phases one after the other.
  initial begin
    live_cfg = '{RST_ONSET_THR, RST_SUSTAIN_THR, RST_ONSET_FRM, RST_PREROLL_MAX,
                 RST_EOU_SILENCE, RST_MIN_SEGMENT, RST_SEGMENT_CAP, RST_VAD_FRM_LEN};
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset configuration first, untouched.
    repeat (40) in_q.push_back(random_item());
    wait_idle();

    // Directed part on a small configuration: 32-sample frames, onset after
    // two speech frames, preroll of 100, close after 64 samples of silence,
    // segments up to 100 samples discarded, room for 1000 samples.
    apply_config('{16'h8000, 16'h4000, 8'd2, 16'd100, 20'd64, 20'd100, 20'd1000, 16'd32});
    // A flush with nothing open, an empty frame, and the unused command.
    in_q.push_back(frame_item(CMD_FLUSH_ALL, 0, VAD_ABSENT, 0));
    in_q.push_back(frame_item(CMD_FRAME, 0, VAD_RAN, 16'hFFFF));
    in_q.push_back(frame_item(CMD_UNUSED, 32, VAD_RAN, 16'hFFFF));
    // Preroll builds up from frames with and without an opinion.
    in_q.push_back(frame_item(CMD_FRAME, 32, VAD_RAN, 0));
    in_q.push_back(frame_item(CMD_FRAME, 20, VAD_ABSENT, 16'hFFFF));
    in_q.push_back(frame_item(CMD_FRAME, 32, VAD_FAILED, 16'hFFFF));
    in_q.push_back(frame_item(CMD_FRAME, 32, VAD_UNDEFINED, 16'hFFFF));
    in_q.push_back(frame_item(CMD_FRAME, 33, VAD_RAN, 16'hFFFF));
    // Onset exactly on the threshold, then the segment opens with preroll.
    in_q.push_back(frame_item(CMD_FRAME, 32, VAD_RAN, 16'h8000));
    in_q.push_back(frame_item(CMD_FRAME, 32, VAD_RAN, 16'hFFFF));
    // Sustain exactly on its threshold, then silence up to end of utterance.
    in_q.push_back(frame_item(CMD_FRAME, 32, VAD_RAN, 16'h4000));
    in_q.push_back(frame_item(CMD_FRAME, 32, VAD_RAN, 16'h3FFF));
    in_q.push_back(frame_item(CMD_FRAME, 32, VAD_RAN, 0));
    // The largest frame possible is far beyond capacity.
    in_q.push_back(frame_item(CMD_FRAME, 20'hFFFFF, VAD_ABSENT, 0));
    // Open a short segment and overflow it with a long frame.
    in_q.push_back(frame_item(CMD_FRAME, 32, VAD_RAN, 16'hFFFF));
    in_q.push_back(frame_item(CMD_FRAME, 32, VAD_RAN, 16'hFFFF));
    in_q.push_back(frame_item(CMD_FRAME, 1000, VAD_ABSENT, 16'hFFFF));
    // Long enough for the minimum-length flush to emit it.
    in_q.push_back(frame_item(CMD_FRAME, 32, VAD_RAN, 16'hFFFF));
    in_q.push_back(frame_item(CMD_FRAME, 32, VAD_RAN, 16'hFFFF));
    in_q.push_back(frame_item(CMD_FLUSH_MIN, 0, VAD_ABSENT, 0));
    // Too short for the minimum-length flush, so it is discarded.
    in_q.push_back(frame_item(CMD_FRAME, 32, VAD_RAN, 16'hFFFF));
    in_q.push_back(frame_item(CMD_FRAME, 32, VAD_RAN, 16'hFFFF));
    in_q.push_back(frame_item(CMD_FLUSH_MIN, 20'hFFFFF, VAD_UNDEFINED, 16'hFFFF));
    // Same length again, closed by an empty frame instead.
    in_q.push_back(frame_item(CMD_FRAME, 32, VAD_RAN, 16'hFFFF));
    in_q.push_back(frame_item(CMD_FRAME, 32, VAD_RAN, 16'hFFFF));
    in_q.push_back(frame_item(CMD_FRAME, 0, VAD_RAN, 16'hFFFF));
    wait_idle();

    run_random_phase(CFG_TYPICAL, 70);
    run_random_phase(CFG_TYPICAL, 70);
    run_random_phase(CFG_HIGHEST, 50);
    run_random_phase(CFG_TYPICAL, 70);
    run_random_phase(CFG_LOWEST, 60);
    run_random_phase(CFG_TYPICAL, 70);
    run_random_phase(CFG_ONSET_ZERO, 50);
    run_random_phase(CFG_TYPICAL, 70);
    run_random_phase(CFG_NO_CAPACITY, 20);
    run_random_phase(CFG_TYPICAL, 70);
    run_random_phase(CFG_TYPICAL, 70);

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Input side: an accepted transaction is run through the predictor at the
  // edge that accepts it, and the driver is told to move on.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      step_endpointer(in_item_i);
      void'(in_q.pop_front());
      in_taken = 1'b1;
    end
  end

  // Driver: bursts of back-to-back transactions separated by random gaps,
  // with the odd long burst that has no gap at all. A transaction once
  // offered stays on the bus unchanged until it is taken.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i = 1'b0;
    end else if (!in_valid_i || in_taken) begin
      in_taken = 1'b0;
      if (send_burst == 0 && send_gap == 0) begin
        send_burst = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                 : $urandom_range(1, 12);
        send_gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      end
      if (send_burst == 0) begin
        in_valid_i = 1'b0;
        send_gap--;
      end else if (in_q.size() != 0) begin
        in_valid_i = 1'b1;
        in_item_i  = in_q[0];
        send_burst--;
      end else begin
        in_valid_i = 1'b0;
      end
    end
  end

  // Receiver: runs of readiness followed by stalls, sometimes long runs with
  // no stall, independent of the sender's pattern.
  always @(negedge clk_i) begin
    if (rdy_run == 0 && rdy_stall == 0) begin
      rdy_run   = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                              : $urandom_range(1, 10);
      rdy_stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
    end
    if (rdy_run != 0) begin
      out_ready_i = 1'b1;
      rdy_run--;
    end else begin
      out_ready_i = 1'b0;
      rdy_stall--;
    end
  end

  // Monitor: each event taken from the block must match the oldest one due.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (events_due.size() == 0) begin
        flag_error($sformatf("unexpected event: res %0d cause %0d start %0d len %0d",
                             out_item_o.event_res, out_item_o.cause,
                             out_item_o.start_sample, out_item_o.seg_len));
      end else begin
        due_ev = events_due.pop_front();
        check_field("event_res",    64'(out_item_o.event_res),    64'(due_ev.event_res));
        check_field("cause",        64'(out_item_o.cause),        64'(due_ev.cause));
        check_field("start_sample", 64'(out_item_o.start_sample), 64'(due_ev.start_sample));
        check_field("seg_len",      64'(out_item_o.seg_len),      64'(due_ev.seg_len));
      end
    end
  end

  // Watchdog: a block that stops moving transactions ends the run.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

endmodule

@@ vad_utterance_segmenter_unit.f @@
design/vus_pkg.sv
design/vus_cfg_regs.sv
design/vus_seg_core.sv
design/vad_utterance_segmenter_unit.sv
verif/tb_vad_utterance_segmenter_unit.sv
